// ----- hdl/lfs_pkg.sv -----
// Shared codes and widths for the line follower steering controller.
// Holds phase, drive, status and register index codes; no dependencies.
package lfs_pkg;

  // Configuration port widths
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  typedef logic [3:0] phase_t;
  typedef logic [1:0] drive_t;
  typedef logic [2:0] status_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Controller phases
  localparam phase_t PH_FOLLOW   = 4'd0;
  localparam phase_t PH_LEFT     = 4'd1;
  localparam phase_t PH_RIGHT    = 4'd2;
  localparam phase_t PH_COUNTER  = 4'd3;
  localparam phase_t PH_FWDHOLD  = 4'd4;
  localparam phase_t PH_APPROACH = 4'd5;
  localparam phase_t PH_PAUSE    = 4'd6;
  localparam phase_t PH_TURN     = 4'd7;
  localparam phase_t PH_HOLD     = 4'd8;

  // Drive commands
  localparam drive_t DRV_STOP  = 2'd0;
  localparam drive_t DRV_FWD   = 2'd1;
  localparam drive_t DRV_LEFT  = 2'd2;
  localparam drive_t DRV_RIGHT = 2'd3;

  // Status codes
  localparam status_t ST_FOLLOW  = 3'd0;
  localparam status_t ST_RECOVER = 3'd1;
  localparam status_t ST_LOST    = 3'd2;
  localparam status_t ST_DOCKING = 3'd3;
  localparam status_t ST_DOCKED  = 3'd4;

  // Register indexes
  localparam cfg_idx_t REG_OFFLINE_LIMIT   = 3'd0;
  localparam cfg_idx_t REG_LEFT_SWEEP      = 3'd1;
  localparam cfg_idx_t REG_RIGHT_SWEEP     = 3'd2;
  localparam cfg_idx_t REG_FORWARD_HOLD    = 3'd3;
  localparam cfg_idx_t REG_DOCK_APPROACH   = 3'd4;
  localparam cfg_idx_t REG_DOCK_PAUSE      = 3'd5;
  localparam cfg_idx_t REG_DOCK_TURN       = 3'd6;
  localparam cfg_idx_t REG_DOCK_HOLD       = 3'd7;

  // Register reset values
  localparam logic [7:0] RST_OFFLINE_LIMIT = 8'd100;
  localparam logic [7:0] RST_LEFT_SWEEP    = 8'd50;
  localparam logic [7:0] RST_RIGHT_SWEEP   = 8'd100;
  localparam logic [7:0] RST_FORWARD_HOLD  = 8'd10;
  localparam logic [7:0] RST_DOCK_APPROACH = 8'd100;
  localparam logic [9:0] RST_DOCK_PAUSE    = 10'd200;
  localparam logic [7:0] RST_DOCK_TURN     = 8'd200;
  localparam logic [7:0] RST_DOCK_HOLD     = 8'd50;

endpackage

// ----- hdl/line_follower_steering_fsm_unit.sv -----
// Line follower steering and docking controller, top level.
// Depends on lfs_pkg for phase, drive, status and register codes.
//
// Usage:
//   Input channel s_axis: one word per tick. tuser carries the action
//   (0 sensor sample, 1 dock command); tdata carries the three sensor bits.
//   Output channel m_axis: exactly one word per input word, with the drive
//   command and status.
//   Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i;
//   write only while no word is in flight.
// Pipeline and throughput:
//   An input word is captured in the input register, the next state and
//   result are computed by combinational logic and stored in the output
//   register, which drives m_axis_tvalid_o. One word per cycle is sustained
//   while m_axis_tready_i stays high; the single state update per word is
//   the only loop.
// Reset: registers return to their default values, controller follows the
//   line with cleared counters, and both channels are empty.
// Stall: while m_axis_tready_i is low the output word holds; one more input
//   word is taken into the input register, then s_axis_tready_o drops.
module line_follower_steering_fsm_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input channel
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i,  // [0] center_black, [1] left_black,
                                                         // [2] right_black, [7:3] zero
  input  logic                          s_axis_tuser_i,  // [0] action
  // Output channel
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [7:0]                    m_axis_tdata_o,  // [1:0] drive, [4:2] status,
                                                         // [7:5] zero
  // Configuration write port
  input  logic                          cfg_we_i,
  input  lfs_pkg::cfg_idx_t             cfg_idx_i,
  input  logic [lfs_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import lfs_pkg::*;

  // Configuration registers
  logic [7:0] offline_limit_q, left_sweep_q, right_sweep_q, forward_hold_q;
  logic [7:0] dock_approach_q, dock_turn_q, dock_hold_q;
  logic [9:0] dock_pause_q;

  // Input register
  logic a_valid_q;
  logic a_action_q, a_c_q, a_l_q, a_r_q;

  // Output register
  logic    o_valid_q;
  drive_t  o_drive_q;
  status_t o_status_q;

  // Controller state
  phase_t     phase_q, phase_d;
  logic       lz_q, lz_d;
  logic [7:0] oc_q, oc_d;
  logic [7:0] si_q, si_d;
  logic [9:0] hc_q, hc_d;
  logic       ctr_q, ctr_d;

  // Handshake
  logic s_fire, a_adv;

  // Following tick results
  logic [1:0] fol_n;
  logic [7:0] oc_inc;
  phase_t     fol_ph;
  logic       fol_lz;
  logic [7:0] fol_oc, fol_si;
  drive_t     fol_drive;
  status_t    fol_status;

  // Step results and chain control
  drive_t     drive_c;
  status_t    status_c;
  logic [7:0] si_n;
  logic       go_counter, go_fwd, go_pause, go_hold, take_follow, from_hit, hit;
  logic [9:0] ctr_h, fwd_h, pause_h, hold_h;

  assign a_adv           = a_valid_q && (!o_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !a_valid_q || a_adv;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  assign m_axis_tvalid_o = o_valid_q;
  assign m_axis_tdata_o  = {3'b000, o_status_q, o_drive_q};

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offline_limit_q <= RST_OFFLINE_LIMIT;
      left_sweep_q    <= RST_LEFT_SWEEP;
      right_sweep_q   <= RST_RIGHT_SWEEP;
      forward_hold_q  <= RST_FORWARD_HOLD;
      dock_approach_q <= RST_DOCK_APPROACH;
      dock_pause_q    <= RST_DOCK_PAUSE;
      dock_turn_q     <= RST_DOCK_TURN;
      dock_hold_q     <= RST_DOCK_HOLD;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_OFFLINE_LIMIT: offline_limit_q <= cfg_data_i[7:0];
        REG_LEFT_SWEEP:    left_sweep_q    <= cfg_data_i[7:0];
        REG_RIGHT_SWEEP:   right_sweep_q   <= cfg_data_i[7:0];
        REG_FORWARD_HOLD:  forward_hold_q  <= cfg_data_i[7:0];
        REG_DOCK_APPROACH: dock_approach_q <= cfg_data_i[7:0];
        REG_DOCK_PAUSE:    dock_pause_q    <= cfg_data_i[9:0];
        REG_DOCK_TURN:     dock_turn_q     <= cfg_data_i[7:0];
        REG_DOCK_HOLD:     dock_hold_q     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Capture input word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (s_fire) begin
      a_valid_q <= 1'b1;
    end else if (a_adv) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      a_action_q <= s_axis_tuser_i;
      a_c_q      <= s_axis_tdata_i[0];
      a_l_q      <= s_axis_tdata_i[1];
      a_r_q      <= s_axis_tdata_i[2];
    end
  end

  // Following tick: steer toward the line or count off-line ticks; past the limit, sweep or go lost
  always_comb begin
    fol_n      = {1'b0, a_c_q} + {1'b0, a_l_q} + {1'b0, a_r_q};
    oc_inc     = (oc_q == 8'hFF) ? 8'hFF : oc_q + 8'd1;
    fol_ph     = PH_FOLLOW;
    fol_lz     = lz_q;
    fol_oc     = oc_q;
    fol_si     = si_q;
    fol_drive  = DRV_FWD;
    fol_status = ST_FOLLOW;
    if (fol_n == 2'd1) begin
      fol_oc = 8'd0;
      fol_lz = 1'b0;
      if (!a_c_q) begin
        fol_drive = a_l_q ? DRV_LEFT : DRV_RIGHT;
      end
    end else if (fol_n == 2'd2) begin
      fol_oc = 8'd0;
      fol_lz = 1'b1;
      if (a_c_q) begin
        fol_drive = !a_l_q ? DRV_LEFT : DRV_RIGHT;
      end
    end else begin
      fol_oc = oc_inc;
      if (oc_inc > offline_limit_q) begin
        fol_si = 8'd0;
        if (left_sweep_q != 8'd0) begin
          fol_ph     = PH_LEFT;
          fol_drive  = DRV_LEFT;
          fol_status = ST_RECOVER;
        end else if (right_sweep_q != 8'd0) begin
          fol_ph     = PH_RIGHT;
          fol_drive  = DRV_RIGHT;
          fol_status = ST_RECOVER;
        end else begin
          fol_oc     = 8'd0;
          fol_drive  = DRV_STOP;
          fol_status = ST_LOST;
        end
      end
    end
  end

  // Next state and result for the word in the input register
  always_comb begin
    phase_d     = phase_q;
    lz_d        = lz_q;
    oc_d        = oc_q;
    si_d        = si_q;
    hc_d        = hc_q;
    ctr_d       = ctr_q;
    drive_c     = DRV_FWD;
    status_c    = ST_FOLLOW;
    si_n        = si_q + 8'd1;
    hit         = lz_q ? !a_c_q : a_c_q;
    go_counter  = 1'b0;
    go_fwd      = 1'b0;
    go_pause    = 1'b0;
    go_hold     = 1'b0;
    take_follow = 1'b0;
    from_hit    = 1'b0;
    ctr_h       = hc_q;
    fwd_h       = hc_q;
    pause_h     = hc_q;
    hold_h      = hc_q;

    // Dispatch on command and phase
    if (a_action_q) begin
      oc_d = 8'd0;
      si_d = 8'd0;
      if (dock_approach_q != 8'd0) begin
        phase_d  = PH_APPROACH;
        drive_c  = DRV_FWD;
        status_c = ST_DOCKING;
      end else begin
        go_pause = 1'b1;
        pause_h  = dock_pause_q;
      end
    end else begin
      unique case (phase_q) inside
        PH_LEFT, PH_RIGHT: begin
          if (hit) begin
            ctr_d      = (phase_q == PH_LEFT);
            go_counter = 1'b1;
            ctr_h      = {2'b00, si_q};
            from_hit   = 1'b1;
          end else if (si_n != 8'd0 &&
                       si_n < ((phase_q == PH_LEFT) ? left_sweep_q : right_sweep_q)) begin
            si_d     = si_n;
            drive_c  = (phase_q == PH_LEFT) ? DRV_LEFT : DRV_RIGHT;
            status_c = ST_RECOVER;
          end else if (phase_q == PH_LEFT && right_sweep_q != 8'd0) begin
            si_d     = 8'd0;
            phase_d  = PH_RIGHT;
            drive_c  = DRV_RIGHT;
            status_c = ST_RECOVER;
          end else begin
            si_d     = (phase_q == PH_LEFT) ? 8'd0 : si_n;
            phase_d  = PH_FOLLOW;
            oc_d     = 8'd0;
            drive_c  = DRV_STOP;
            status_c = ST_LOST;
          end
        end
        PH_APPROACH: begin
          si_d = si_n;
          if ((a_c_q && a_l_q && a_r_q) || si_n == 8'd0 || si_n >= dock_approach_q) begin
            go_pause = 1'b1;
            pause_h  = dock_pause_q;
          end else begin
            drive_c  = DRV_FWD;
            status_c = ST_DOCKING;
          end
        end
        PH_TURN: begin
          si_d = si_n;
          if (!a_c_q || si_n == 8'd0 || si_n >= dock_turn_q) begin
            go_hold = 1'b1;
            hold_h  = {2'b00, dock_hold_q};
          end else begin
            drive_c  = DRV_RIGHT;
            status_c = ST_DOCKING;
          end
        end
        PH_COUNTER: go_counter = 1'b1;
        PH_FWDHOLD: go_fwd     = 1'b1;
        PH_PAUSE:   go_pause   = 1'b1;
        PH_HOLD:    go_hold    = 1'b1;
        default:    take_follow = 1'b1;
      endcase
    end

    // Counter-turn for the sweep length
    if (go_counter) begin
      if (ctr_h != 10'd0) begin
        phase_d  = PH_COUNTER;
        hc_d     = ctr_h - 10'd1;
        drive_c  = ctr_d ? DRV_RIGHT : DRV_LEFT;
        status_c = ST_RECOVER;
      end else begin
        go_fwd = 1'b1;
        fwd_h  = {2'b00, forward_hold_q};
      end
    end

    // Forward hold, then fall back to following
    if (go_fwd) begin
      if (fwd_h != 10'd0) begin
        phase_d  = PH_FWDHOLD;
        hc_d     = fwd_h - 10'd1;
        drive_c  = DRV_FWD;
        status_c = ST_RECOVER;
      end else begin
        phase_d = PH_FOLLOW;
        hc_d    = 10'd0;
        if (from_hit) begin
          drive_c  = DRV_FWD;
          status_c = ST_FOLLOW;
        end else begin
          take_follow = 1'b1;
        end
      end
    end

    // Dock pause, then right turn or hold
    if (go_pause) begin
      if (pause_h != 10'd0) begin
        phase_d  = PH_PAUSE;
        hc_d     = pause_h - 10'd1;
        drive_c  = DRV_FWD;
        status_c = ST_DOCKING;
      end else begin
        si_d = 8'd0;
        hc_d = 10'd0;
        if (dock_turn_q != 8'd0) begin
          phase_d  = PH_TURN;
          drive_c  = DRV_RIGHT;
          status_c = ST_DOCKING;
        end else begin
          go_hold = 1'b1;
          hold_h  = {2'b00, dock_hold_q};
        end
      end
    end

    // Dock hold, then stop as docked
    if (go_hold) begin
      if (hold_h != 10'd0) begin
        phase_d  = PH_HOLD;
        hc_d     = hold_h - 10'd1;
        drive_c  = DRV_RIGHT;
        status_c = ST_DOCKING;
      end else begin
        phase_d  = PH_FOLLOW;
        hc_d     = 10'd0;
        drive_c  = DRV_STOP;
        status_c = ST_DOCKED;
      end
    end

    // Treat the word as a following tick
    if (take_follow) begin
      phase_d  = fol_ph;
      lz_d     = fol_lz;
      oc_d     = fol_oc;
      si_d     = fol_si;
      drive_c  = fol_drive;
      status_c = fol_status;
    end
  end

  // Advance controller state once per word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FOLLOW;
      lz_q    <= 1'b0;
      oc_q    <= 8'd0;
      si_q    <= 8'd0;
      hc_q    <= 10'd0;
      ctr_q   <= 1'b0;
    end else if (a_adv) begin
      phase_q <= phase_d;
      lz_q    <= lz_d;
      oc_q    <= oc_d;
      si_q    <= si_d;
      hc_q    <= hc_d;
      ctr_q   <= ctr_d;
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (a_adv) begin
      o_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      o_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      o_drive_q  <= drive_c;
      o_status_q <= status_c;
    end
  end

  // An empty output register never blocks the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !o_valid_q |-> s_axis_tready_o)
    else $error("input stalled with empty output register");

  // A dock command always yields a docking or docked word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_adv && a_action_q) |=> (o_valid_q &&
      (o_status_q == ST_DOCKING || o_status_q == ST_DOCKED)))
    else $error("dock command did not report docking");

  // Lost and docked words always stop the drive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_valid_q && (o_status_q == ST_LOST || o_status_q == ST_DOCKED)) |->
      (o_drive_q == DRV_STOP))
    else $error("lost or docked word without stop");

  // Docking phases run with a cleared off-line count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_APPROACH || phase_q == PH_PAUSE ||
     phase_q == PH_TURN || phase_q == PH_HOLD) |-> (oc_q == 8'd0))
    else $error("off-line count set during docking");

endmodule

// ----- verif/lfs_steering_checker.sv -----
// Scoreboard for the line follower steering controller: predicts one drive word
// per accepted input word and compares it with the output stream.
// Depends on lfs_pkg for phase, drive, status and register index codes.
module lfs_steering_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [7:0]                     in_data_i,   // [0] center, [1] left, [2] right
  input  logic                           in_user_i,   // [0] action
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [7:0]                     out_data_i,  // [1:0] drive, [4:2] status
  input  logic                           cfg_we_i,
  input  lfs_pkg::cfg_idx_t              cfg_idx_i,
  input  logic [lfs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                    pending_o,
  output int unsigned                    errors_o
);
  import lfs_pkg::*;

  typedef struct packed {
    drive_t  drive;
    status_t status;
  } steer_cmd_t;

  // Register mirror
  logic [7:0] lim_offline, sweep_left_max, sweep_right_max, fwd_hold_len;
  logic [7:0] approach_max, turn_max, hold_len;
  logic [9:0] pause_len;

  // Controller mirror
  phase_t     ph;
  logic       zone_station;
  logic [7:0] off_cnt, sweep_idx;
  logic [9:0] hold_cnt;
  logic       ctr_right;
  drive_t     cmd_drive;
  status_t    cmd_status;

  steer_cmd_t  cmd_queue[$];
  int unsigned mismatch_cnt = 0;
  int unsigned out_count    = 0;

  task automatic put_cmd(input drive_t d, input status_t s);
    cmd_drive  = d;
    cmd_status = s;
  endtask

  // Walk the timed phases; done is low when the chain falls back to following
  // without producing a command for this tick.
  task automatic timed_advance(output bit done);
    bit busy;
    busy = 1'b1;
    done = 1'b0;
    while (busy) begin
      case (ph)
        PH_COUNTER: begin
          if (hold_cnt != 10'd0) begin
            hold_cnt = hold_cnt - 10'd1;
            put_cmd(ctr_right ? DRV_RIGHT : DRV_LEFT, ST_RECOVER);
            done = 1'b1;
            busy = 1'b0;
          end else begin
            ph       = PH_FWDHOLD;
            hold_cnt = {2'b00, fwd_hold_len};
          end
        end
        PH_FWDHOLD: begin
          if (hold_cnt != 10'd0) begin
            hold_cnt = hold_cnt - 10'd1;
            put_cmd(DRV_FWD, ST_RECOVER);
            done = 1'b1;
          end else begin
            ph = PH_FOLLOW;
          end
          busy = 1'b0;
        end
        PH_PAUSE: begin
          if (hold_cnt != 10'd0) begin
            hold_cnt = hold_cnt - 10'd1;
            put_cmd(DRV_FWD, ST_DOCKING);
            done = 1'b1;
            busy = 1'b0;
          end else begin
            sweep_idx = 8'd0;
            if (turn_max != 8'd0) begin
              ph = PH_TURN;
              put_cmd(DRV_RIGHT, ST_DOCKING);
              done = 1'b1;
              busy = 1'b0;
            end else begin
              ph       = PH_HOLD;
              hold_cnt = {2'b00, hold_len};
            end
          end
        end
        PH_HOLD: begin
          if (hold_cnt != 10'd0) begin
            hold_cnt = hold_cnt - 10'd1;
            put_cmd(DRV_RIGHT, ST_DOCKING);
          end else begin
            ph = PH_FOLLOW;
            put_cmd(DRV_STOP, ST_DOCKED);
          end
          done = 1'b1;
          busy = 1'b0;
        end
        default: begin
          ph   = PH_FOLLOW;
          busy = 1'b0;
        end
      endcase
    end
  endtask

  task automatic begin_right_sweep();
    sweep_idx = 8'd0;
    if (sweep_right_max != 8'd0) begin
      ph = PH_RIGHT;
      put_cmd(DRV_RIGHT, ST_RECOVER);
    end else begin
      ph      = PH_FOLLOW;
      off_cnt = 8'd0;
      put_cmd(DRV_STOP, ST_LOST);
    end
  endtask

  task automatic begin_pause();
    bit done;
    ph       = PH_PAUSE;
    hold_cnt = pause_len;
    timed_advance(done);
  endtask

  // Plain following: steer toward the line or count an off-line tick; past the limit, sweep or go lost
  task automatic follow_tick(input logic c, input logic l, input logic r);
    logic [1:0] n;
    n  = {1'b0, c} + {1'b0, l} + {1'b0, r};
    ph = PH_FOLLOW;
    if (n == 2'd1) begin
      off_cnt      = 8'd0;
      zone_station = 1'b0;
      if (!c && (l || r)) put_cmd(l ? DRV_LEFT : DRV_RIGHT, ST_FOLLOW);
      else put_cmd(DRV_FWD, ST_FOLLOW);
    end else if (n == 2'd2) begin
      off_cnt      = 8'd0;
      zone_station = 1'b1;
      if (c && (!l || !r)) put_cmd(!l ? DRV_LEFT : DRV_RIGHT, ST_FOLLOW);
      else put_cmd(DRV_FWD, ST_FOLLOW);
    end else begin
      put_cmd(DRV_FWD, ST_FOLLOW);
      if (off_cnt < 8'd255) off_cnt = off_cnt + 8'd1;
      if (off_cnt > lim_offline) begin
        sweep_idx = 8'd0;
        if (sweep_left_max != 8'd0) begin
          ph = PH_LEFT;
          put_cmd(DRV_LEFT, ST_RECOVER);
        end else begin
          begin_right_sweep();
        end
      end
    end
  endtask

  // One sampled tick of the left or right search sweep
  task automatic sweep_tick(input logic c);
    bit hit;
    bit done;
    hit = zone_station ? !c : c;
    if (hit) begin
      ctr_right = (ph == PH_LEFT);
      hold_cnt  = {2'b00, sweep_idx};
      ph        = PH_COUNTER;
      timed_advance(done);
      if (!done) put_cmd(DRV_FWD, ST_FOLLOW);
    end else begin
      sweep_idx = sweep_idx + 8'd1;
      if (ph == PH_LEFT) begin
        if (sweep_idx != 8'd0 && sweep_idx < sweep_left_max) put_cmd(DRV_LEFT, ST_RECOVER);
        else begin_right_sweep();
      end else begin
        if (sweep_idx != 8'd0 && sweep_idx < sweep_right_max) begin
          put_cmd(DRV_RIGHT, ST_RECOVER);
        end else begin
          ph      = PH_FOLLOW;
          off_cnt = 8'd0;
          put_cmd(DRV_STOP, ST_LOST);
        end
      end
    end
  endtask

  // Advance the mirror by one input word and leave its command in cmd_*
  task automatic next_cmd(input logic dock, input logic c, input logic l, input logic r);
    bit done;
    if (dock) begin
      off_cnt   = 8'd0;
      sweep_idx = 8'd0;
      if (approach_max != 8'd0) begin
        ph = PH_APPROACH;
        put_cmd(DRV_FWD, ST_DOCKING);
      end else begin
        begin_pause();
      end
    end else begin
      case (ph)
        PH_LEFT, PH_RIGHT: sweep_tick(c);
        PH_APPROACH: begin
          sweep_idx = sweep_idx + 8'd1;
          if ((c && l && r) || sweep_idx == 8'd0 || sweep_idx >= approach_max) begin_pause();
          else put_cmd(DRV_FWD, ST_DOCKING);
        end
        PH_TURN: begin
          sweep_idx = sweep_idx + 8'd1;
          if (!c || sweep_idx == 8'd0 || sweep_idx >= turn_max) begin
            ph       = PH_HOLD;
            hold_cnt = {2'b00, hold_len};
            timed_advance(done);
          end else begin
            put_cmd(DRV_RIGHT, ST_DOCKING);
          end
        end
        PH_COUNTER, PH_FWDHOLD, PH_PAUSE, PH_HOLD: begin
          timed_advance(done);
          if (!done) follow_tick(c, l, r);
        end
        default: follow_tick(c, l, r);
      endcase
    end
  endtask

  task automatic note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%s", msg);
  endtask

  // Sample both channels and the write port at each rising edge
  always @(posedge clk_i) begin
    steer_cmd_t want;
    steer_cmd_t fresh;
    if (!rst_ni) begin
      lim_offline     = RST_OFFLINE_LIMIT;
      sweep_left_max  = RST_LEFT_SWEEP;
      sweep_right_max = RST_RIGHT_SWEEP;
      fwd_hold_len    = RST_FORWARD_HOLD;
      approach_max    = RST_DOCK_APPROACH;
      pause_len       = RST_DOCK_PAUSE;
      turn_max        = RST_DOCK_TURN;
      hold_len        = RST_DOCK_HOLD;
      ph              = PH_FOLLOW;
      zone_station    = 1'b0;
      off_cnt         = 8'd0;
      sweep_idx       = 8'd0;
      hold_cnt        = 10'd0;
      ctr_right       = 1'b0;
      cmd_queue.delete();
    end else begin
      // Check the result word against the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (cmd_queue.size() == 0) begin
          note_mismatch($sformatf("MISMATCH: output word %0d with nothing pending (drive %0d status %0d)",
                                  out_count, out_data_i[1:0], out_data_i[4:2]));
        end else begin
          want = cmd_queue.pop_front();
          if (out_data_i[1:0] != want.drive || out_data_i[4:2] != want.status)
            note_mismatch($sformatf("MISMATCH: word %0d drive exp %0d got %0d, status exp %0d got %0d",
                                    out_count, want.drive, out_data_i[1:0],
                                    want.status, out_data_i[4:2]));
        end
        out_count++;
      end
      // Predict the command for an accepted input word
      if (in_valid_i && in_ready_i) begin
        next_cmd(in_user_i, in_data_i[0], in_data_i[1], in_data_i[2]);
        fresh.drive  = cmd_drive;
        fresh.status = cmd_status;
        cmd_queue.push_back(fresh);
      end
      // Track register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_OFFLINE_LIMIT: lim_offline     = cfg_data_i[7:0];
          REG_LEFT_SWEEP:    sweep_left_max  = cfg_data_i[7:0];
          REG_RIGHT_SWEEP:   sweep_right_max = cfg_data_i[7:0];
          REG_FORWARD_HOLD:  fwd_hold_len    = cfg_data_i[7:0];
          REG_DOCK_APPROACH: approach_max    = cfg_data_i[7:0];
          REG_DOCK_PAUSE:    pause_len       = cfg_data_i;
          REG_DOCK_TURN:     turn_max        = cfg_data_i[7:0];
          REG_DOCK_HOLD:     hold_len        = cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
    pending_o <= cmd_queue.size();
    errors_o  <= mismatch_cnt;
  end

endmodule

// ----- verif/tb_line_follower_steering_fsm_unit.sv -----
// Testbench top for the line follower steering controller: drives sensor and
// dock words, random stalls and register settings; lfs_steering_checker scores.
// Depends on lfs_pkg, line_follower_steering_fsm_unit and lfs_steering_checker.
module tb_line_follower_steering_fsm_unit;
  import lfs_pkg::*;

  localparam logic ACT_SENSE   = 1'b0;
  localparam logic ACT_DOCK    = 1'b1;
  localparam int   LONG_STALL  = 300;
  localparam int   CYCLE_LIMIT = 400000;
  localparam int   PHASE_WORDS = 84;

  logic                  clk      = 1'b0;
  logic                  rst_n    = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata  = 8'd0;
  logic                  s_tuser  = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [7:0]            m_tdata;
  logic                  cfg_we   = 1'b0;
  cfg_idx_t              cfg_idx  = REG_OFFLINE_LIMIT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int unsigned pend;
  int unsigned err_cnt;

  // Stimulus knobs
  logic [9:0] cfg_vals [8];
  logic [7:0] cur_limit  = RST_OFFLINE_LIMIT;
  bit         tx_idle    = 1'b1;
  bit         rx_idle    = 1'b1;
  int         stall_req  = 0;
  int         stall_seen = 0;
  int         rx_gap     = 0;
  int         rx_long    = 0;

  line_follower_steering_fsm_unit u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  lfs_steering_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (s_tvalid),
    .in_ready_i  (s_tready),
    .in_data_i   (s_tdata),
    .in_user_i   (s_tuser),
    .out_valid_i (m_tvalid),
    .out_ready_i (m_tready),
    .out_data_i  (m_tdata),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .pending_o   (pend),
    .errors_o    (err_cnt)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // End the run if it hangs
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [9:0] pick_reg(input bit wide);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 10'd0;
    if (r == 1) return wide ? 10'h3FF : 10'h0FF;
    if (r == 2) return 10'($urandom_range(7, 40));
    return 10'($urandom_range(0, 6));
  endfunction

  // Receiver: random gaps, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      m_tready <= 1'b0;
      rx_gap   <= 0;
      rx_long  <= 0;
    end else if (rx_long != 0) begin
      m_tready <= 1'b0;
      rx_long  <= rx_long - 1;
    end else if (stall_seen != stall_req) begin
      stall_seen <= stall_req;
      rx_long    <= LONG_STALL;
      m_tready   <= 1'b0;
    end else if (rx_gap != 0) begin
      m_tready <= 1'b0;
      rx_gap   <= rx_gap - 1;
    end else begin
      m_tready <= 1'b1;
      rx_gap   <= rx_idle ? pick_gap() : 0;
    end
  end

  // Offer one word after an optional gap and hold it until accepted
  task automatic send_word(input logic act, input logic [2:0] rlc);
    int gap;
    gap = tx_idle ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {5'b00000, rlc};
    do @(posedge clk); while (!s_tready);
  endtask

  // Stop offering and wait for every predicted word to come out
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pend != 0);
    repeat (3) @(posedge clk);
  endtask

  // Write all eight registers; spare high bits of 8-bit registers are noise
  task automatic load_config();
    for (int i = 0; i < 8; i++) begin
      cfg_we  <= 1'b1;
      cfg_idx <= cfg_idx_t'(i);
      if (i == REG_DOCK_PAUSE) cfg_data <= cfg_vals[i];
      else cfg_data <= {2'($urandom_range(0, 3)), cfg_vals[i][7:0]};
      @(posedge clk);
    end
    cfg_we    <= 1'b0;
    cur_limit = cfg_vals[REG_OFFLINE_LIMIT][7:0];
  endtask

  task automatic set_cfg(input logic [7:0] lim, input logic [7:0] lsw, input logic [7:0] rsw,
                         input logic [7:0] fwd, input logic [7:0] appr, input logic [9:0] pau,
                         input logic [7:0] trn, input logic [7:0] hld);
    cfg_vals[REG_OFFLINE_LIMIT] = {2'b00, lim};
    cfg_vals[REG_LEFT_SWEEP]    = {2'b00, lsw};
    cfg_vals[REG_RIGHT_SWEEP]   = {2'b00, rsw};
    cfg_vals[REG_FORWARD_HOLD]  = {2'b00, fwd};
    cfg_vals[REG_DOCK_APPROACH] = {2'b00, appr};
    cfg_vals[REG_DOCK_PAUSE]    = pau;
    cfg_vals[REG_DOCK_TURN]     = {2'b00, trn};
    cfg_vals[REG_DOCK_HOLD]     = {2'b00, hld};
    load_config();
  endtask

  // One random run: an off-line burst into a sweep, a docking run, or noise
  task automatic run_episode(inout int sent);
    int kind;
    int n;
    int k;
    kind = $urandom_range(0, 9);
    if (kind < 5) begin
      n = (cur_limit < 20) ? int'(cur_limit) + $urandom_range(1, 2) : $urandom_range(1, 20);
      repeat (n) send_word(ACT_SENSE, ($urandom_range(0, 1) != 0) ? 3'b111 : 3'b000);
      k = $urandom_range(1, 10);
      repeat (k) send_word(ACT_SENSE, 3'($urandom));
      sent += n + k;
    end else if (kind < 7) begin
      send_word(ACT_DOCK, 3'($urandom));
      k = $urandom_range(2, 12);
      repeat (k) send_word(ACT_SENSE, ($urandom_range(0, 3) == 0) ? 3'b111 : 3'($urandom));
      sent += k + 1;
    end else begin
      k = $urandom_range(1, 8);
      repeat (k) send_word(($urandom_range(0, 19) == 0) ? ACT_DOCK : ACT_SENSE, 3'($urandom));
      sent += k;
    end
  endtask

  initial begin
    int sent;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: short sweeps and docking steps, sensors given as {right, left, center}
    set_cfg(8'd2, 8'd2, 8'd2, 8'd2, 8'd3, 10'd2, 8'd3, 8'd2);
    send_word(ACT_SENSE, 3'b001);
    send_word(ACT_SENSE, 3'b010);
    send_word(ACT_SENSE, 3'b100);
    send_word(ACT_SENSE, 3'b011);
    send_word(ACT_SENSE, 3'b101);
    send_word(ACT_SENSE, 3'b110);
    // Off-line past the limit, then no hit on either sweep: lost
    send_word(ACT_SENSE, 3'b000);
    send_word(ACT_SENSE, 3'b111);
    send_word(ACT_SENSE, 3'b000);
    repeat (4) send_word(ACT_SENSE, 3'b001);
    // Dock: approach ends on all black, pause, turn ends on center white, hold
    send_word(ACT_DOCK, 3'b111);
    send_word(ACT_SENSE, 3'b111);
    send_word(ACT_SENSE, 3'b000);
    send_word(ACT_SENSE, 3'b000);
    send_word(ACT_SENSE, 3'b110);
    send_word(ACT_SENSE, 3'b000);
    send_word(ACT_SENSE, 3'b000);
    // Sweep that hits at once: nothing to counter-turn, straight to forward hold
    send_word(ACT_SENSE, 3'b000);
    send_word(ACT_SENSE, 3'b111);
    send_word(ACT_SENSE, 3'b000);
    send_word(ACT_SENSE, 3'b000);
    drain();
    // All steps zero length: dock completes in one tick, off-line goes lost
    set_cfg(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 10'd0, 8'd0, 8'd0);
    send_word(ACT_DOCK, 3'b000);
    send_word(ACT_SENSE, 3'b111);

    // Random phases, each with its own register setting
    for (int p = 0; p < 8; p++) begin
      drain();
      for (int i = 0; i < 8; i++) begin
        if (p == 2) cfg_vals[i] = (i == REG_DOCK_PAUSE) ? 10'h3FF : 10'h0FF;
        else if (p == 5) cfg_vals[i] = 10'd0;
        else cfg_vals[i] = pick_reg(i == REG_DOCK_PAUSE);
      end
      load_config();
      tx_idle = (p != 3) && ($urandom_range(0, 3) != 0);
      rx_idle <= (p != 3) && ($urandom_range(0, 3) != 0);
      // Hold off the receiver while the sender keeps offering
      if (p == 1 || p == 6) stall_req <= stall_req + 1;
      sent = 0;
      while (sent < PHASE_WORDS) run_episode(sent);
    end

    drain();
    repeat (4) @(posedge clk);
    if (err_cnt == 0 && pend == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- line_follower_steering_fsm_unit.f -----
hdl/lfs_pkg.sv
hdl/line_follower_steering_fsm_unit.sv
verif/lfs_steering_checker.sv
verif/tb_line_follower_steering_fsm_unit.sv
